// ----- src/fd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_pkg: shared types and constants of the imu fall detector
// field widths, sensor offsets, register codes, controller states and
// the command/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package fd_pkg;

  localparam int SampleW  = 16;
  localparam int MagW     = 17;  // offset magnitudes reach 33732
  localparam int SqW      = 32;  // squares and sums wrap modulo 2^32
  localparam int CountW   = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 6 * SampleW;
  localparam int OutDataW = 72;

  // sensor offsets in raw counts
  localparam logic [MagW-1:0]        AccOffX = 17'd870;
  localparam logic [MagW-1:0]        AccOffZ = 17'd964;
  localparam logic signed [MagW-1:0] GyrOffX = 17'sd540;
  localparam logic signed [MagW-1:0] GyrOffY = 17'sd200;
  localparam logic signed [MagW-1:0] GyrOffZ = -17'sd287;

  // register reset values
  localparam logic [SqW-1:0]    AccelLowRst  = 32'd905592334;
  localparam logic [SqW-1:0]    AccelHighRst = 32'd1009008743;
  localparam logic [SqW-1:0]    TurnMinRst   = 32'd386535261;
  localparam logic [SqW-1:0]    TurnMaxRst   = 32'd2748695184;
  localparam logic [SqW-1:0]    StillMaxRst  = 32'd1717934;
  localparam logic [CountW-1:0] WindowRst    = 8'd6;
  localparam logic [CountW-1:0] SettleRst    = 8'd10;

  localparam logic [1:0] LastAxis = 2'd2;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [CfgAddrW-1:0] {
    REG_ACCEL_LOW  = 3'd0,
    REG_ACCEL_HIGH = 3'd1,
    REG_TURN_MIN   = 3'd2,
    REG_TURN_MAX   = 3'd3,
    REG_STILL_MAX  = 3'd4,
    REG_WINDOW_LEN = 3'd5,
    REG_SETTLE_LEN = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       square;
    logic [1:0] axis;
    logic       sum_clr;
    logic       sum_add;
    logic       decide;
  } fd_cmd_t;

  typedef struct packed {
    logic out_free;
  } fd_sts_t;

  // result word, fall flag in the lowest bit
  typedef struct packed {
    logic           stage_three_armed;
    logic           stage_two_armed;
    logic           stage_one_armed;
    logic [SqW-1:0] rotation_mag_sq;
    logic [SqW-1:0] accel_mag_sq;
    logic           fall_detected;
  } fd_result_t;

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    return (c < CountMax) ? c + 1'b1 : CountMax;
  endfunction

  // |sample| + offset
  function automatic logic [MagW-1:0] acc_mag(input logic signed [SampleW-1:0] s,
                                              input logic [MagW-1:0] off);
    logic signed [MagW-1:0] ext;
    logic [MagW-1:0]        mag;
    ext = MagW'(s);
    mag = ext[MagW-1] ? MagW'(-ext) : MagW'(ext);
    return mag + off;
  endfunction

  // |sample + offset|
  function automatic logic [MagW-1:0] gyr_mag(input logic signed [SampleW-1:0] s,
                                              input logic signed [MagW-1:0] off);
    logic signed [MagW-1:0] v;
    v = MagW'(s) + off;
    return v[MagW-1] ? MagW'(-v) : MagW'(v);
  endfunction

endpackage

// ----- src/imu_fall_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fall_detector_core: three-stage accelerometer/gyroscope fall detector
// one six-axis sample in, one result out: squared magnitudes, stage flags
// and a fall flag when a settled sample confirms a fall
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata, 96 bits
//  m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata, 72 bits
//  cfg       in         cfg_valid/cfg_ready           cfg_addr, cfg_data
//
//  a sample passes through capture (the cycle of its input transaction),
//  squaring on the two multipliers, one axis at a time, one final add
//  and one stage decision; the result is registered at the decision,
//  and the next sample is taken in the cycle after the decision,
//  while the result may still sit in the output register
//  the decision waits only if that register holds an untaken result
//  rst is synchronous: thresholds return to their defaults, stages disarm
//  cfg_ready is always high; writes are meant for idle periods only
//
module imu_fall_detector_core
  import fd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, 16 bits each from bit 0
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // fall_detected, accel_mag_sq, rotation_mag_sq, stage_one_armed,
  // stage_two_armed, stage_three_armed from bit 0, zero fill above bit 67
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data
);

  fd_cmd_t    cmd;
  fd_sts_t    sts;
  fd_result_t result;

  assign cfg_ready = 1'b1;

  // sequencing
  fd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, stage state and result register
  fd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (result)
  );

  assign m_axis_tdata = {(OutDataW - $bits(fd_result_t))'(0), result};

`ifndef NO_ASSERTIONS
  // a taken sample keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sample taken right after another");

  // stage one and stage two are never armed together
  a_stage_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(result.stage_one_armed && result.stage_two_armed))
    else $error("stage one and stage two both armed");

  // a new result comes only out of the decision cycle
  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a decision cycle");
`endif

endmodule

// ----- src/fd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_ctrl: sequencing state machine of the fall detector
// steps capture, squaring of the three axes, a final add and the stage decision
// ----------------------------------------------------------------------------
module fd_ctrl
  import fd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  fd_sts_t sts,
  output fd_cmd_t cmd
);

  state_t     state, state_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SQUARE;
          axis_next  = '0;
        end
      end
      ST_SQUARE: begin
        if (axis == LastAxis) state_next = ST_ACCUM;
        else axis_next = axis + 2'd1;
      end
      ST_ACCUM: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.axis    = axis;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_SQUARE: begin
        cmd.square  = 1'b1;
        cmd.sum_clr = (axis == 2'd1);
        cmd.sum_add = (axis != 2'd0);
      end
      ST_ACCUM:  cmd.sum_add = 1'b1;
      ST_DECIDE: cmd.decide  = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/fd_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_dpath: datapath of the fall detector
// offset magnitudes, two squaring lanes with accumulators, threshold
// registers, stage flags and counters, and the result register
// ----------------------------------------------------------------------------
module fd_dpath
  import fd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  fd_cmd_t             cmd,
  output fd_sts_t             sts,
  input  logic [InDataW-1:0]  in_data,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fd_result_t          out_data
);

  // threshold registers
  logic [SqW-1:0]    accel_low_sq, accel_high_sq, turn_min_sq, turn_max_sq, still_max_sq;
  logic [CountW-1:0] window_len, settle_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_low_sq  <= AccelLowRst;
      accel_high_sq <= AccelHighRst;
      turn_min_sq   <= TurnMinRst;
      turn_max_sq   <= TurnMaxRst;
      still_max_sq  <= StillMaxRst;
      window_len    <= WindowRst;
      settle_len    <= SettleRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ACCEL_LOW:  accel_low_sq  <= cfg_data;
        REG_ACCEL_HIGH: accel_high_sq <= cfg_data;
        REG_TURN_MIN:   turn_min_sq   <= cfg_data;
        REG_TURN_MAX:   turn_max_sq   <= cfg_data;
        REG_STILL_MAX:  still_max_sq  <= cfg_data;
        REG_WINDOW_LEN: window_len    <= cfg_data[CountW-1:0];
        REG_SETTLE_LEN: settle_len    <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // magnitudes captured with the sample
  logic [MagW-1:0] acc_m [3];
  logic [MagW-1:0] gyr_m [3];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_m[0] <= acc_mag(in_data[0*SampleW +: SampleW], AccOffX);
      acc_m[1] <= acc_mag(in_data[1*SampleW +: SampleW], '0);
      acc_m[2] <= acc_mag(in_data[2*SampleW +: SampleW], AccOffZ);
      gyr_m[0] <= gyr_mag(in_data[3*SampleW +: SampleW], GyrOffX);
      gyr_m[1] <= gyr_mag(in_data[4*SampleW +: SampleW], GyrOffY);
      gyr_m[2] <= gyr_mag(in_data[5*SampleW +: SampleW], GyrOffZ);
    end
  end

  // one axis per cycle on each lane
  logic [MagW-1:0]   acc_op, gyr_op;
  logic [2*MagW-1:0] acc_full, gyr_full;
  logic [SqW-1:0]    acc_prod, gyr_prod, acc_sum, rot_sum;

  always_comb begin
    case (cmd.axis)
      2'd0:    begin acc_op = acc_m[0]; gyr_op = gyr_m[0]; end
      2'd1:    begin acc_op = acc_m[1]; gyr_op = gyr_m[1]; end
      default: begin acc_op = acc_m[2]; gyr_op = gyr_m[2]; end
    endcase
  end

  assign acc_full = acc_op * acc_op;
  assign gyr_full = gyr_op * gyr_op;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      acc_prod <= acc_full[SqW-1:0];
      gyr_prod <= gyr_full[SqW-1:0];
    end
    if (cmd.sum_add) begin
      acc_sum <= (cmd.sum_clr ? '0 : acc_sum) + acc_prod;
      rot_sum <= (cmd.sum_clr ? '0 : rot_sum) + gyr_prod;
    end
  end

  // stage state
  logic              impact_armed, turn_armed, settle_armed;
  logic [CountW-1:0] impact_count, turn_count, settle_count;
  logic              impact_armed_next, turn_armed_next, settle_armed_next, fall_next;
  logic [CountW-1:0] impact_count_next, turn_count_next, settle_count_next;

  always_comb begin
    impact_armed_next = impact_armed;
    turn_armed_next   = turn_armed;
    settle_armed_next = settle_armed;
    impact_count_next = impact_count;
    turn_count_next   = turn_count;
    settle_count_next = settle_count;
    fall_next         = 1'b0;

    // settle wait, then stillness check
    if (settle_armed_next) begin
      settle_count_next = bump(settle_count_next);
      if (settle_count_next >= settle_len) begin
        fall_next         = (rot_sum <= still_max_sq);
        settle_armed_next = 1'b0;
        settle_count_next = '0;
      end
    end
    // timeouts look at the counters only
    if (turn_count_next >= window_len) begin
      turn_armed_next = 1'b0;
      turn_count_next = '0;
    end
    if (impact_count_next >= window_len) begin
      impact_armed_next = 1'b0;
      impact_count_next = '0;
    end
    // rotation burst inside the window
    if (turn_armed_next) begin
      turn_count_next = bump(turn_count_next);
      if (rot_sum >= turn_min_sq && rot_sum <= turn_max_sq) begin
        settle_armed_next = 1'b1;
        turn_armed_next   = 1'b0;
        turn_count_next   = '0;
      end
    end
    // upper acceleration bound
    if (impact_armed_next) begin
      impact_count_next = bump(impact_count_next);
      if (acc_sum >= accel_high_sq) begin
        turn_armed_next   = 1'b1;
        impact_armed_next = 1'b0;
        impact_count_next = '0;
      end
    end
    if (acc_sum >= accel_low_sq && !turn_armed_next) impact_armed_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      impact_armed <= 1'b0;
      turn_armed   <= 1'b0;
      settle_armed <= 1'b0;
      impact_count <= '0;
      turn_count   <= '0;
      settle_count <= '0;
    end else if (cmd.decide) begin
      impact_armed <= impact_armed_next;
      turn_armed   <= turn_armed_next;
      settle_armed <= settle_armed_next;
      impact_count <= impact_count_next;
      turn_count   <= turn_count_next;
      settle_count <= settle_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.decide) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_data.fall_detected     <= fall_next;
      out_data.accel_mag_sq      <= acc_sum;
      out_data.rotation_mag_sq   <= rot_sum;
      out_data.stage_one_armed   <= impact_armed_next;
      out_data.stage_two_armed   <= turn_armed_next;
      out_data.stage_three_armed <= settle_armed_next;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule
